// ----- hw/rtl/dsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types, constants and helpers of the decimal schoolbook multiplier.
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam int MAX_DIGITS  = 32;
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int PROD_DEPTH  = 2 * MAX_DIGITS;
    localparam int PROD_ADDR_W = $clog2(PROD_DEPTH);
    localparam int STEP_W      = $clog2(PROD_DEPTH + 1);
    localparam int DIGIT_W     = 4;
    localparam int ACC_W       = 7;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // Item kinds carried on s_tuser.
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_SECOND = 2'd1;
    localparam logic [1:0] KIND_GO     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic                clear;
        logic                step;
        logic [DIGIT_W-1:0]  a_digit;
    } dsm_cell_ctrl_t;

    // Quotient by ten of a value up to 99: multiply by 205, shift by 11.
    function automatic logic [DIGIT_W-1:0] dsm_div10(input logic [ACC_W-1:0] v);
        logic [14:0] prod;
        prod = {8'd0, v} * 15'd205;
        return prod[14:11];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/decimal_schoolbook_multiplier_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_schoolbook_multiplier_core
// Streaming multiplier of two unsigned decimal numbers, up to 32 digits each.
// ----------------------------------------------------------------------------
// Digits of both operands arrive least significant first, one transfer each,
// and a go transfer produces the product as a stream of digits, least
// significant first, with tlast on the most significant one. A go transfer
// runs the calculation through a row of 32 digit cells that holds the second
// operand and the running sum in carry-save form; each cycle feeds one digit
// of the first operand (zeros after the last one), and the cell at the low
// end hands out one finished product digit per cycle into a 64-entry product
// RAM. The product is then read out of that RAM's single port at one digit
// per cycle while the downstream side keeps m_tready high. The input side is
// held off from the go transfer until the last digit has been read into the
// output register.
// ----------------------------------------------------------------------------
module decimal_schoolbook_multiplier_core
    import dsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] digit_in, [7:4] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [3:0] product_digit, [7:4] zero
    output logic             m_tlast    // last_digit
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       n1_reg, n1_next;
    logic [CNT_W-1:0]       n2_reg, n2_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [STEP_W-1:0]      steps_reg, steps_next;
    logic [PROD_ADDR_W-1:0] hi_reg, hi_next;
    logic [PROD_ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [DIGIT_W-1:0]     m_digit_reg;
    logic                   m_last_reg;

    logic [DIGIT_W-1:0]     a_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]     prod_mem [PROD_DEPTH];

    logic                   in_xfer;
    logic                   out_free;
    logic                   calc_run;
    logic                   emit_rd;
    logic                   calc_done;
    logic                   emit_done;
    logic [DIGIT_W-1:0]     digit_clamped;
    logic [STEP_W-1:0]      len_sum;
    logic                   load_first;
    logic                   load_second;
    logic                   go;
    dsm_cell_ctrl_t         cell_ctrl;
    logic [DIGIT_W-1:0]     d_chain [MAX_DIGITS + 1];

    assign in_xfer       = s_tvalid && s_tready;
    assign out_free      = !m_tvalid_reg || m_tready;
    assign digit_clamped = (s_tdata[3:0] > DIGIT_MAX) ? DIGIT_MAX : s_tdata[3:0];
    assign len_sum       = STEP_W'(n1_reg) + STEP_W'(n2_reg);
    assign calc_done     = (step_reg == steps_reg - STEP_W'(1));
    assign emit_done     = (rd_addr_reg == hi_reg);

    // Decode of the accepted item. A full operand drops further digits.
    always_comb begin
        load_first  = 1'b0;
        load_second = 1'b0;
        go          = 1'b0;
        case (s_tuser)
            KIND_FIRST:  load_first  = in_xfer && (n1_reg < CNT_W'(MAX_DIGITS));
            KIND_SECOND: load_second = in_xfer && (n2_reg < CNT_W'(MAX_DIGITS));
            KIND_GO:     go          = in_xfer;
            default:     go          = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (go)                   state_next = ST_CALC;
            ST_CALC: if (calc_done)            state_next = ST_EMIT;
            ST_EMIT: if (out_free && emit_done) state_next = ST_IDLE;
            default:                           state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready = 1'b0;
        calc_run = 1'b0;
        emit_rd  = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_CALC: calc_run = 1'b1;
            ST_EMIT: emit_rd  = out_free;
            default: s_tready = 1'b0;
        endcase
    end

    // Counters and bookkeeping.
    always_comb begin
        n1_next       = n1_reg;
        n2_next       = n2_reg;
        step_next     = step_reg;
        steps_next    = steps_reg;
        hi_next       = hi_reg;
        rd_addr_next  = rd_addr_reg;
        m_tvalid_next = m_tvalid_reg;

        if (load_first) begin
            n1_next = n1_reg + CNT_W'(1);
        end
        if (load_second) begin
            n2_next = n2_reg + CNT_W'(1);
        end
        if (go) begin
            // An empty product still runs one step so that digit zero is written.
            step_next  = '0;
            steps_next = (len_sum == '0) ? STEP_W'(1) : len_sum;
            hi_next    = '0;
        end
        if (calc_run) begin
            step_next = step_reg + STEP_W'(1);
            if (d_chain[0] != '0) begin
                hi_next = step_reg[PROD_ADDR_W-1:0];
            end
            if (calc_done) begin
                n1_next      = '0;
                n2_next      = '0;
                rd_addr_next = '0;
            end
        end
        if (emit_rd) begin
            rd_addr_next  = rd_addr_reg + PROD_ADDR_W'(1);
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            n1_reg       <= '0;
            n2_reg       <= '0;
            step_reg     <= '0;
            steps_reg    <= STEP_W'(1);
            hi_reg       <= '0;
            rd_addr_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n1_reg       <= n1_next;
            n2_reg       <= n2_next;
            step_reg     <= step_next;
            steps_reg    <= steps_next;
            hi_reg       <= hi_next;
            rd_addr_reg  <= rd_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // First operand digits, written at the fill count.
    always_ff @(posedge aclk) begin
        if (load_first) begin
            a_mem[n1_reg[DIG_IDX_W-1:0]] <= digit_clamped;
        end
    end

    // Product RAM: one write per calculation step, one registered read that
    // doubles as the output register and holds while the result is stalled.
    always_ff @(posedge aclk) begin
        if (calc_run) begin
            prod_mem[step_reg[PROD_ADDR_W-1:0]] <= d_chain[0];
        end
        if (emit_rd) begin
            m_digit_reg <= prod_mem[rd_addr_reg];
            m_last_reg  <= emit_done;
        end
    end

    // The first operand is fed one digit per step, then zeros flush the row.
    always_comb begin
        cell_ctrl.clear   = go;
        cell_ctrl.step    = calc_run;
        cell_ctrl.a_digit = (step_reg < STEP_W'(n1_reg)) ?
                            a_mem[step_reg[DIG_IDX_W-1:0]] : '0;
    end

    // Nothing enters the top of the row.
    assign d_chain[MAX_DIGITS] = '0;

    for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_cell
        dsm_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .b_we     (load_second && (n2_reg[DIG_IDX_W-1:0] == DIG_IDX_W'(j))),
            .b_wdata  (digit_clamped),
            .b_active (CNT_W'(j) < n2_reg),
            .d_in     (d_chain[j + 1]),
            .d_out    (d_chain[j])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_digit_reg};
    assign m_tlast  = m_last_reg;

    // A go transfer starts the calculation from step zero.
    a_go_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> (state_reg == ST_CALC) && (step_reg == '0))
        else $error("go transfer did not start the calculation");

    // The step counter never runs past the product length.
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> (step_reg < steps_reg))
        else $error("calculation step beyond product length");

    // Readout never passes the most significant digit.
    a_rd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rd_addr_reg <= hi_reg))
        else $error("product readout past the top digit");

    // A stalled digit holds its value until it is taken.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled product digit changed");

    // Operand fill counts stay within the digit capacity.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (n1_reg <= CNT_W'(MAX_DIGITS)) && (n2_reg <= CNT_W'(MAX_DIGITS)))
        else $error("operand count beyond capacity");

endmodule

`default_nettype wire

// ----- hw/rtl/dsm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_cell
// One digit position of the carry-save accumulator row.
// ----------------------------------------------------------------------------
module dsm_cell
    import dsm_pkg::*;
(
    input  wire logic                aclk,
    input  wire dsm_cell_ctrl_t      ctrl,
    input  wire logic                b_we,
    input  wire logic [DIGIT_W-1:0]  b_wdata,
    input  wire logic                b_active,
    input  wire logic [DIGIT_W-1:0]  d_in,
    output logic      [DIGIT_W-1:0]  d_out
);

    logic [DIGIT_W-1:0] b_reg;
    logic [DIGIT_W-1:0] s_reg;
    logic [DIGIT_W-1:0] c_reg;
    logic [DIGIT_W-1:0] c_next;
    logic [DIGIT_W-1:0] b_eff;
    logic [7:0]         mul;
    logic [ACC_W-1:0]   v;

    // Position value: sum digit plus the carry held here plus this row's partial
    // product. The digit moves one position down, the carry stays here.
    always_comb begin
        b_eff  = b_active ? b_reg : '0;
        mul    = {4'd0, ctrl.a_digit} * {4'd0, b_eff};
        v      = {3'd0, s_reg} + {3'd0, c_reg} + mul[ACC_W-1:0];
        c_next = dsm_div10(v);
        d_out  = DIGIT_W'(v - ACC_W'(c_next) * ACC_W'(10));
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_reg <= b_wdata;
        end
        if (ctrl.clear) begin
            s_reg <= '0;
            c_reg <= '0;
        end else if (ctrl.step) begin
            s_reg <= d_in;
            c_reg <= c_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_decimal_schoolbook_multiplier_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_schoolbook_multiplier_core
// Self-checking bench for the streaming decimal schoolbook multiplier.
// ----------------------------------------------------------------------------
// A queue of digit loads and go transfers is filled up front: a short directed
// list of corner products, then random multiplication jobs of mostly small
// operands with a few full-width and overfull ones. A clocked driver sends the
// queue in bursts with random gaps, and a clocked monitor takes the product
// digits under a random stall pattern. Every accepted input transfer updates a
// local long-multiplication model, which queues the product digits that the
// block has to return; the monitor checks each returned digit against them.
// ----------------------------------------------------------------------------
module tb_decimal_schoolbook_multiplier_core;
    import dsm_pkg::*;

    // Kind code that the block must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Cycles without any transfer before the run is declared hung. The worst
    // legitimate silence is a full 32 by 32 compute plus the longest stall.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles of quiet at the end, after the last expected digit has arrived.
    localparam int TAIL_CYCLES    = 200;
    // Random input transfers wanted after the directed list.
    localparam int RANDOM_ITEMS   = 376;

    typedef struct {
        logic [1:0]          kind;
        logic [DIGIT_W-1:0]  digit;
        bit                  wait_drain;   // hold off until all digits are back
    } stim_item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0]  digit;
        logic                last;
    } prod_digit_t;

    // DUT signals. Every input has a known value from time zero.
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [3:0] digit_in, [7:4] zero
    logic [1:0]  s_tuser  = '0;    // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [3:0] product_digit, [7:4] zero
    logic        m_tlast;          // last_digit

    decimal_schoolbook_multiplier_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Stimulus waiting to be sent, and product digits still owed by the block.
    stim_item_t  items_to_send[$];
    prod_digit_t product_digits_due[$];
    int          fail_count = 0;

    // Local copy of the operand stores and digit counts.
    logic [DIGIT_W-1:0] first_digits  [MAX_DIGITS];
    logic [DIGIT_W-1:0] second_digits [MAX_DIGITS];
    logic [CNT_W-1:0]   first_count  = '0;
    logic [CNT_W-1:0]   second_count = '0;

    // ------------------------------------------------------------------------
    // Long-multiplication model.
    // ------------------------------------------------------------------------

    // Multiplies the loaded operands row by row in base ten, strips leading
    // zeros (keeping one digit) and queues the digits, least significant first.
    task automatic multiply_operands();
        logic [DIGIT_W-1:0] store [PROD_DEPTH];
        int n1, n2, len, carry, acc;
        prod_digit_t pd;
        n1 = int'(first_count);
        n2 = int'(second_count);
        for (int k = 0; k < PROD_DEPTH; k++) store[k] = '0;
        for (int i = 0; i < n1; i++) begin
            carry = 0;
            for (int j = 0; j < n2; j++) begin
                acc = int'(first_digits[i]) * int'(second_digits[j])
                      + int'(store[i + j]) + carry;
                carry = acc / 10;
                store[i + j] = DIGIT_W'(acc % 10);
            end
            // The final carry of a row lands one place above the row.
            if (carry != 0 && i + n2 < PROD_DEPTH)
                store[i + n2] = DIGIT_W'(int'(store[i + n2]) + carry);
        end
        len = (n1 + n2 == 0) ? 1 : n1 + n2;
        while (len > 1 && store[len - 1] == '0) len--;
        for (int k = 0; k < len; k++) begin
            pd.digit = store[k];
            pd.last  = (k + 1 == len);
            product_digits_due.push_back(pd);
        end
        first_count  = '0;
        second_count = '0;
    endtask

    // Applies one accepted input transfer to the model.
    task automatic apply_item(input stim_item_t it);
        logic [DIGIT_W-1:0] d;
        // Digits above nine are saturated; loads into a full operand are lost.
        d = (it.digit > DIGIT_MAX) ? DIGIT_MAX : it.digit;
        case (it.kind)
            KIND_FIRST: begin
                if (first_count < MAX_DIGITS) begin
                    first_digits[first_count[DIG_IDX_W-1:0]] = d;
                    first_count++;
                end
            end
            KIND_SECOND: begin
                if (second_count < MAX_DIGITS) begin
                    second_digits[second_count[DIG_IDX_W-1:0]] = d;
                    second_count++;
                end
            end
            KIND_GO: multiply_operands();
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------

    task automatic add_item(input logic [1:0] kind, input logic [DIGIT_W-1:0] digit,
                            input bit wait_drain = 1'b0);
        stim_item_t it;
        it.kind       = kind;
        it.digit      = digit;
        it.wait_drain = wait_drain;
        items_to_send.push_back(it);
    endtask

    // Picks a digit count: mostly short operands, sometimes long, rarely more
    // than the block can hold so that the overflow loads get dropped.
    function automatic int pick_length();
        int r;
        r = $urandom_range(15, 0);
        if (r == 0)  return 0;
        if (r <= 10) return $urandom_range(6, 1);
        if (r <= 13) return $urandom_range(MAX_DIGITS, 7);
        if (r == 14) return MAX_DIGITS;
        return $urandom_range(MAX_DIGITS + 4, MAX_DIGITS + 1);
    endfunction

    // One multiplication job: the loads of both operands interleaved at random,
    // an occasional ignored transfer, then the go transfer.
    task automatic add_product_job(input int n1, input int n2, input bit all_nines,
                                   input bit wait_drain);
        int la, lb;
        logic [DIGIT_W-1:0] d;
        logic [1:0] k;
        la = 0;
        lb = 0;
        while (la < n1 || lb < n2) begin
            if (la < n1 && (lb >= n2 || $urandom_range(1, 0) == 0)) begin
                k = KIND_FIRST;
                la++;
            end else begin
                k = KIND_SECOND;
                lb++;
            end
            if (all_nines)
                d = DIGIT_MAX;
            else if ($urandom_range(7, 0) == 0)
                d = DIGIT_W'($urandom_range(15, 10));
            else
                d = DIGIT_W'($urandom_range(9, 0));
            add_item(k, d);
            if ($urandom_range(31, 0) == 0)
                add_item(KIND_UNUSED, DIGIT_W'($urandom_range(15, 0)));
        end
        add_item(KIND_GO, DIGIT_W'($urandom_range(15, 0)), wait_drain);
    endtask

    task automatic build_stimulus();
        int target;
        // Both operands empty: the product is a lone zero.
        add_item(KIND_GO, 4'd0);
        // Only one operand loaded counts as a multiplication by zero.
        add_item(KIND_FIRST, 4'd5);
        add_item(KIND_GO, 4'd0);
        add_item(KIND_SECOND, 4'd7);
        add_item(KIND_GO, 4'd15);
        // Largest single digits.
        add_item(KIND_FIRST, 4'd9);
        add_item(KIND_SECOND, 4'd9);
        add_item(KIND_GO, 4'd0);
        // Digits above nine saturate to nine.
        add_item(KIND_FIRST, 4'd15);
        add_item(KIND_SECOND, 4'd10);
        add_item(KIND_GO, 4'd0);
        // The unused kind changes nothing.
        add_item(KIND_UNUSED, 4'd15);
        add_item(KIND_UNUSED, 4'd0);
        // 50 times 2: the carry ripples into a new top digit.
        add_item(KIND_FIRST, 4'd0);
        add_item(KIND_FIRST, 4'd5);
        add_item(KIND_SECOND, 4'd2);
        add_item(KIND_GO, 4'd0);
        // Zero operands with several digits: leading zeros are stripped.
        add_item(KIND_FIRST, 4'd0);
        add_item(KIND_FIRST, 4'd0);
        add_item(KIND_SECOND, 4'd0);
        add_item(KIND_GO, 4'd0, 1'b1);
        // Smallest nonzero product.
        add_item(KIND_FIRST, 4'd1);
        add_item(KIND_SECOND, 4'd1);
        add_item(KIND_GO, 4'd0);

        // Random part. It opens with the widest product, both operands
        // overfilled with nines, its go transfer sent only once the block has drained.
        target = items_to_send.size() + RANDOM_ITEMS;
        add_product_job(MAX_DIGITS + 4, MAX_DIGITS + 3, 1'b1, 1'b1);
        while (items_to_send.size() < target)
            add_product_job(pick_length(), pick_length(), 1'b0,
                            $urandom_range(7, 0) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of transfers separated by random gaps.
    // ------------------------------------------------------------------------
    stim_item_t cur_item;
    bit         slot_full  = 1'b0;
    int         gap_left   = 0;
    int         burst_left = 1;

    always @(posedge aclk) begin : send_items
        logic       valid_next;
        stim_item_t nxt;
        int         r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            valid_next = s_tvalid;
            if (s_tvalid && s_tready) begin
                apply_item(cur_item);
                slot_full  = 1'b0;
                valid_next = 1'b0;
            end
            if (!slot_full) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (items_to_send.size() > 0 &&
                             !(items_to_send[0].wait_drain &&
                               product_digits_due.size() != 0)) begin
                    nxt        = items_to_send.pop_front();
                    cur_item   = nxt;
                    slot_full  = 1'b1;
                    valid_next = 1'b1;
                    s_tdata   <= {4'b0000, nxt.digit};
                    s_tuser   <= nxt.kind;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // New burst; the gap before it is often zero, so long
                        // back-to-back stretches occur as well.
                        burst_left = $urandom_range(24, 1);
                        r = $urandom_range(5, 0);
                        if (r < 2)       gap_left = 0;
                        else if (r < 5)  gap_left = $urandom_range(6, 1);
                        else             gap_left = $urandom_range(20, 1);
                    end
                end
            end
            s_tvalid <= valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random stall pattern on m_tready and the digit check.
    // ------------------------------------------------------------------------
    int ready_hold = 0;

    always @(posedge aclk) begin : take_digits
        prod_digit_t due;
        logic        level;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (product_digits_due.size() == 0) begin
                    $error("unexpected product digit transfer: product_digit %0d, last_digit %0b",
                           m_tdata[3:0], m_tlast);
                    fail_count++;
                end else begin
                    due = product_digits_due.pop_front();
                    if (m_tdata[3:0] !== due.digit) begin
                        $error("product_digit mismatch: expected %0d, actual %0d",
                               due.digit, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tlast !== due.last) begin
                        $error("last_digit mismatch: expected %0b, actual %0b",
                               due.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            // Ready is held for a random number of cycles, long when high and
            // short when low, so stalls hit every digit position.
            if (ready_hold > 0) begin
                ready_hold--;
            end else begin
                level      = ($urandom_range(3, 0) != 0);
                ready_hold = level ? $urandom_range(40, 0) : $urandom_range(12, 0);
                m_tready  <= level;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog on cycles without any transfer.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing: fill the queue, release reset, wait for the end.
    // ------------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (items_to_send.size() != 0 || slot_full) @(posedge aclk);
        while (product_digits_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && product_digits_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dsm_pkg.sv
hw/rtl/dsm_cell.sv
hw/rtl/decimal_schoolbook_multiplier_core.sv
tb/sv/tb_decimal_schoolbook_multiplier_core.sv
